/* sv/zoom2x_pkg.sv */
// shared constants and pixel arithmetic for the 2x zoom window core
`default_nettype none

package zoom2x_pkg;

    localparam int DEF_FRAME_WIDTH   = 256;
    localparam int DEF_FRAME_HEIGHT  = 192;
    localparam int DEF_WINDOW_WIDTH  = 128;
    localparam int DEF_WINDOW_HEIGHT = 96;

    localparam int PIX_W   = 16;
    localparam int CHAN_W  = 5;
    localparam int CFG_W   = 7;
    localparam int COORD_W = 8;

    localparam logic [PIX_W-1:0] SEPARATOR_COLOUR = 16'hBD45;
    localparam logic [CHAN_W-1:0] TINT_MAX    = 5'd31;
    localparam logic [5:0]        TINT_OFFSET = 6'd3;
    localparam logic [7:0]        RECIP3      = 8'd171;

    typedef enum logic [0:0] {
        CFG_WINDOW_LEFT = 1'b0,
        CFG_WINDOW_TOP  = 1'b1
    } cfg_index_t;

    // truncated channel average, opaque flag set
    function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        logic [CHAN_W:0] r_sum;
        logic [CHAN_W:0] g_sum;
        logic [CHAN_W:0] b_sum;
        r_sum = {1'b0, a[4:0]}   + {1'b0, b[4:0]};
        g_sum = {1'b0, a[9:5]}   + {1'b0, b[9:5]};
        b_sum = {1'b0, a[14:10]} + {1'b0, b[14:10]};
        return {1'b1, b_sum[CHAN_W:1], g_sum[CHAN_W:1], r_sum[CHAN_W:1]};
    endfunction

    // grey tint: sum/3 by reciprocal multiply, exact for sums below 512
    function automatic logic [PIX_W-1:0] tint(input logic [PIX_W-1:0] p);
        logic [6:0]  sum;
        logic [14:0] prod;
        logic [5:0]  c;
        logic [CHAN_W-1:0] c_sat;
        sum   = 7'(p[4:0]) + 7'(p[9:5]) + 7'(p[14:10]);
        prod  = 15'(sum) * 15'(RECIP3);
        c     = 6'(prod[14:9]) + TINT_OFFSET;
        c_sat = (c > 6'(TINT_MAX)) ? TINT_MAX : c[CHAN_W-1:0];
        return {1'b1, c_sat, 2'b00, c_sat[4:2], 1'b0, c_sat[4:1]};
    endfunction

endpackage

`default_nettype wire

/* sv/zoom2x_rgb555_window_core.sv */
// 2x zoom of an rgb555 pixel stream inside a window, with line store and output register
`default_nettype none

// Accepts one source pixel per clock in raster order (frame_start marks the first pixel of
// a frame) and, for each source pixel inside the window at (window_left, window_top), gives
// one transfer with its 2x2 zoomed block once its right, lower and diagonal neighbours are
// in: blended on the window's left half, a separator colour on the column before the middle,
// repeated on the right half, plus a grey tint of the pixel. Pixels of the frame's last row
// and column give no transfer. The line store is a single memory read and written at the
// same address in the cycle the pixel is accepted; the block result passes the stage 1 and
// output registers, and the core keeps one pixel per clock as long as m_ready stays high.
// Write the window registers only while the core is idle.
module zoom2x_rgb555_window_core
    import zoom2x_pkg::*;
#(
    parameter int FRAME_WIDTH   = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT  = DEF_FRAME_HEIGHT,
    parameter int WINDOW_WIDTH  = DEF_WINDOW_WIDTH,
    parameter int WINDOW_HEIGHT = DEF_WINDOW_HEIGHT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [PIX_W-1:0]   s_pixel,
    input  wire logic               s_frame_start,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [COORD_W-1:0]      m_zoom_col,
    output logic [COORD_W-1:0]      m_zoom_row,
    output logic [PIX_W-1:0]        m_out_top_left,
    output logic [PIX_W-1:0]        m_out_top_right,
    output logic [PIX_W-1:0]        m_out_bottom_left,
    output logic [PIX_W-1:0]        m_out_bottom_right,
    output logic [COORD_W-1:0]      m_source_col,
    output logic [COORD_W-1:0]      m_source_row,
    output logic [PIX_W-1:0]        m_tinted,
    output logic                    m_last_block
);

    localparam int XW = $clog2(FRAME_WIDTH);
    localparam int YW = $clog2(FRAME_HEIGHT);
    localparam int CW = $clog2(FRAME_WIDTH + WINDOW_WIDTH + 128);
    localparam int RW = $clog2(FRAME_HEIGHT + WINDOW_HEIGHT + 128);

    logic [PIX_W-1:0] line_store_mem [FRAME_WIDTH];

    logic [XW-1:0]    col_reg, col_next;
    logic [YW-1:0]    row_reg, row_next;
    logic [CFG_W-1:0] win_left_reg;
    logic [CFG_W-1:0] win_top_reg;

    logic             s1_valid_reg;
    logic [XW-1:0]    s1_x_reg;
    logic [YW-1:0]    s1_y_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [PIX_W-1:0] above_reg;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] ul_reg;

    logic             in_xfer;
    logic             s1_adv;
    logic [XW-1:0]    cur_x;
    logic [YW-1:0]    cur_y;

    logic [CW-1:0]    tx, wl, dx;
    logic [RW-1:0]    ty, wt, dy;
    logic [CW:0]      dx2;
    logic             in_win, left_half, sep_col, last_hit;
    logic [PIX_W-1:0] tl_pix, tr_pix, bl_pix, br_pix;

    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!m_valid || m_ready);
    assign s_ready   = !s1_valid_reg || s1_adv;
    assign in_xfer   = s_valid && s_ready;

    // position of the incoming pixel and the following one
    always_comb begin
        cur_x    = s_frame_start ? '0 : col_reg;
        cur_y    = s_frame_start ? '0 : row_reg;
        col_next = cur_x + 1'b1;
        row_next = cur_y;
        if (cur_x == XW'(FRAME_WIDTH - 1)) begin
            col_next = '0;
            row_next = (cur_y == YW'(FRAME_HEIGHT - 1)) ? '0 : cur_y + 1'b1;
        end
    end

    // line store, read before write at the same address
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            above_reg              <= line_store_mem[cur_x];
            line_store_mem[cur_x]  <= s_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_x_reg   <= cur_x;
            s1_y_reg   <= cur_y;
            s1_pix_reg <= s_pixel;
        end
    end

    // window check and block for the pixel up and left of the stage 1 pixel
    always_comb begin
        tx        = CW'(s1_x_reg) - 1'b1;
        ty        = RW'(s1_y_reg) - 1'b1;
        wl        = CW'(win_left_reg);
        wt        = RW'(win_top_reg);
        dx        = tx - wl;
        dy        = ty - wt;
        dx2       = {dx, 1'b0};
        in_win    = (s1_x_reg != '0) && (s1_y_reg != '0) &&
                    (tx >= wl) && (tx < wl + CW'(WINDOW_WIDTH)) &&
                    (ty >= wt) && (ty < wt + RW'(WINDOW_HEIGHT));
        left_half = dx2 < (CW + 1)'(WINDOW_WIDTH);
        sep_col   = (dx2 + 1'b1 + 1'b1) == (CW + 1)'(WINDOW_WIDTH);
        last_hit  = (dx == CW'(WINDOW_WIDTH - 1)) && (dy == RW'(WINDOW_HEIGHT - 1));
        if (!left_half) begin
            tl_pix = ul_reg;
            tr_pix = ul_reg;
            bl_pix = ul_reg;
            br_pix = ul_reg;
        end else if (sep_col) begin
            tl_pix = SEPARATOR_COLOUR;
            tr_pix = SEPARATOR_COLOUR;
            bl_pix = SEPARATOR_COLOUR;
            br_pix = SEPARATOR_COLOUR;
        end else begin
            tl_pix = blend(ul_reg, ul_reg);
            tr_pix = blend(ul_reg, above_reg);
            bl_pix = blend(ul_reg, left_reg);
            br_pix = blend(ul_reg, s1_pix_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            win_left_reg <= '0;
            win_top_reg  <= '0;
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
            ul_reg       <= '0;
            m_valid      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_WINDOW_LEFT: win_left_reg <= cfg_data;
                    CFG_WINDOW_TOP:  win_top_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                ul_reg   <= above_reg;
                left_reg <= s1_pix_reg;
                m_valid  <= in_win;
            end else if (m_ready) begin
                m_valid  <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_zoom_col         <= dx2[COORD_W-1:0];
            m_zoom_row         <= {dy[COORD_W-2:0], 1'b0};
            m_out_top_left     <= tl_pix;
            m_out_top_right    <= tr_pix;
            m_out_bottom_left  <= bl_pix;
            m_out_bottom_right <= br_pix;
            m_source_col       <= tx[COORD_W-1:0];
            m_source_row       <= ty[COORD_W-1:0];
            m_tinted           <= tint(ul_reg);
            m_last_block       <= last_hit;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid && !m_ready))
        else $error("input stalled without a blocked output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_block |-> m_zoom_col == COORD_W'(2 * (WINDOW_WIDTH - 1)))
        else $error("last block not on the window's right edge");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_tinted[PIX_W-1])
        else $error("tinted pixel without opaque flag");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= XW'(FRAME_WIDTH - 1)) && (row_reg <= YW'(FRAME_HEIGHT - 1)))
        else $error("pixel counters out of frame");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && in_win && !m_ready |=> m_valid)
        else $error("block lost in output register");
`endif

endmodule

`default_nettype wire

/* verif/tb_zoom2x_rgb555_window_core.sv */
// self-checking testbench for the 2x zoom rgb555 window core with a scoreboard class

typedef struct packed {
    logic [7:0]  zoom_col;
    logic [7:0]  zoom_row;
    logic [15:0] out_top_left;
    logic [15:0] out_top_right;
    logic [15:0] out_bottom_left;
    logic [15:0] out_bottom_right;
    logic [7:0]  source_col;
    logic [7:0]  source_row;
    logic [15:0] tinted;
    logic        last_block;
} zoom_block_t;

class zoom_scoreboard;
    localparam int FRAME_W = zoom2x_pkg::DEF_FRAME_WIDTH;
    localparam int FRAME_H = zoom2x_pkg::DEF_FRAME_HEIGHT;
    localparam int WIN_W   = zoom2x_pkg::DEF_WINDOW_WIDTH;
    localparam int WIN_H   = zoom2x_pkg::DEF_WINDOW_HEIGHT;

    logic [15:0]  line_mem [FRAME_W];
    logic [15:0]  left_px;
    logic [15:0]  upper_left_px;
    int unsigned  col;
    int unsigned  row;
    int unsigned  win_left;
    int unsigned  win_top;
    zoom_block_t  pending_blocks [$];
    int unsigned  errors;

    function new();
        foreach (line_mem[i]) line_mem[i] = '0;
        left_px       = '0;
        upper_left_px = '0;
        col           = 0;
        row           = 0;
        win_left      = 0;
        win_top       = 0;
        errors        = 0;
    endfunction

    function void apply_register(zoom2x_pkg::cfg_index_t idx, logic [6:0] value);
        case (idx)
            zoom2x_pkg::CFG_WINDOW_LEFT: win_left = value;
            zoom2x_pkg::CFG_WINDOW_TOP:  win_top  = value;
            default: ;
        endcase
    endfunction

    function logic [15:0] avg_rgb(logic [15:0] a, logic [15:0] b);
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] bl;
        r  = a[4:0] + b[4:0];
        g  = a[9:5] + b[9:5];
        bl = a[14:10] + b[14:10];
        return {1'b1, bl[5:1], g[5:1], r[5:1]};
    endfunction

    function logic [15:0] grey_tint(logic [15:0] p);
        int unsigned c;
        c = (32'(p[4:0]) + 32'(p[9:5]) + 32'(p[14:10])) / 3 + 3;
        if (c > 31) c = 31;
        return {1'b1, 5'(c), 5'(c >> 2), 5'(c >> 1)};
    endfunction

    function void note_pixel(logic [15:0] px, logic fs);
        int unsigned x;
        int unsigned y;
        int unsigned tx;
        int unsigned ty;
        int unsigned dx;
        int unsigned dy;
        logic [15:0] above;
        logic [15:0] src;
        zoom_block_t blk;
        if (fs) begin
            col = 0;
            row = 0;
        end
        x = col;
        y = row;
        if (x >= FRAME_W) x = 0;
        if (y >= FRAME_H) y = 0;
        above = line_mem[x];
        if (x > 0 && y > 0) begin
            tx = x - 1;
            ty = y - 1;
            if (tx >= win_left && tx < win_left + WIN_W &&
                ty >= win_top && ty < win_top + WIN_H) begin
                dx  = tx - win_left;
                dy  = ty - win_top;
                src = upper_left_px;
                if (2 * dx < WIN_W) begin
                    if (2 * dx + 2 == WIN_W) begin
                        blk.out_top_left     = zoom2x_pkg::SEPARATOR_COLOUR;
                        blk.out_top_right    = zoom2x_pkg::SEPARATOR_COLOUR;
                        blk.out_bottom_left  = zoom2x_pkg::SEPARATOR_COLOUR;
                        blk.out_bottom_right = zoom2x_pkg::SEPARATOR_COLOUR;
                    end else begin
                        blk.out_top_left     = avg_rgb(src, src);
                        blk.out_top_right    = avg_rgb(src, above);
                        blk.out_bottom_left  = avg_rgb(src, left_px);
                        blk.out_bottom_right = avg_rgb(src, px);
                    end
                end else begin
                    blk.out_top_left     = src;
                    blk.out_top_right    = src;
                    blk.out_bottom_left  = src;
                    blk.out_bottom_right = src;
                end
                blk.zoom_col   = 8'(2 * dx);
                blk.zoom_row   = 8'(2 * dy);
                blk.source_col = 8'(tx);
                blk.source_row = 8'(ty);
                blk.tinted     = grey_tint(src);
                blk.last_block = (dx == WIN_W - 1) && (dy == WIN_H - 1);
                pending_blocks.push_back(blk);
            end
        end
        upper_left_px = above;
        left_px       = px;
        line_mem[x]   = px;
        x++;
        if (x >= FRAME_W) begin
            x = 0;
            y++;
            if (y >= FRAME_H) y = 0;
        end
        col = x;
        row = y;
    endfunction

    task report(string msg);
        if (errors < 40) $display("mismatch: %s", msg);
        errors++;
    endtask

    task compare_field(string name, zoom_block_t want, logic [15:0] got_v, logic [15:0] want_v);
        if (got_v !== want_v)
            report($sformatf("%s got %h want %h at source (%0d,%0d)",
                             name, got_v, want_v, want.source_col, want.source_row));
    endtask

    task check_block(zoom_block_t got);
        zoom_block_t want;
        if (pending_blocks.size() == 0) begin
            report($sformatf("unexpected block at source (%0d,%0d)",
                             got.source_col, got.source_row));
        end else begin
            want = pending_blocks.pop_front();
            compare_field("zoom_col", want, 16'(got.zoom_col), 16'(want.zoom_col));
            compare_field("zoom_row", want, 16'(got.zoom_row), 16'(want.zoom_row));
            compare_field("out_top_left", want, got.out_top_left, want.out_top_left);
            compare_field("out_top_right", want, got.out_top_right, want.out_top_right);
            compare_field("out_bottom_left", want, got.out_bottom_left, want.out_bottom_left);
            compare_field("out_bottom_right", want, got.out_bottom_right,
                          want.out_bottom_right);
            compare_field("source_col", want, 16'(got.source_col), 16'(want.source_col));
            compare_field("source_row", want, 16'(got.source_row), 16'(want.source_row));
            compare_field("tinted", want, got.tinted, want.tinted);
            compare_field("last_block", want, 16'(got.last_block), 16'(want.last_block));
        end
    endtask
endclass

module tb_zoom2x_rgb555_window_core;
    import zoom2x_pkg::*;

    localparam longint      TIMEOUT     = 80_000_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned DRAIN_LIMIT = 200_000;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [0:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [PIX_W-1:0]  s_pixel;
    logic              s_frame_start;
    logic              m_valid;
    logic              m_ready;
    logic [7:0]        m_zoom_col;
    logic [7:0]        m_zoom_row;
    logic [15:0]       m_out_top_left;
    logic [15:0]       m_out_top_right;
    logic [15:0]       m_out_bottom_left;
    logic [15:0]       m_out_bottom_right;
    logic [7:0]        m_source_col;
    logic [7:0]        m_source_row;
    logic [15:0]       m_tinted;
    logic              m_last_block;

    zoom_scoreboard sb;
    zoom_block_t    seen_block;
    int unsigned    pixels_taken = 0;
    int unsigned    cfg_taken = 0;
    bit             hold_req = 1'b0;

    logic [15:0] directed_px [24] = '{
        16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h001F, 16'h03E0, 16'h7C00, 16'h8001,
        16'h0421, 16'h5555, 16'hAAAA, 16'h7BDE, 16'hFFFE, 16'h0000, 16'hFFFF, 16'h0001,
        16'h7FFF, 16'h8000, 16'h3DEF, 16'hC210, 16'h1234, 16'hEDCB, 16'h7C1F, 16'h83E0
    };

    zoom2x_rgb555_window_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_pixel            (s_pixel),
        .s_frame_start      (s_frame_start),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_zoom_col         (m_zoom_col),
        .m_zoom_row         (m_zoom_row),
        .m_out_top_left     (m_out_top_left),
        .m_out_top_right    (m_out_top_right),
        .m_out_bottom_left  (m_out_bottom_left),
        .m_out_bottom_right (m_out_bottom_right),
        .m_source_col       (m_source_col),
        .m_source_row       (m_source_row),
        .m_tinted           (m_tinted),
        .m_last_block       (m_last_block)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_block = '{zoom_col: m_zoom_col, zoom_row: m_zoom_row,
                               out_top_left: m_out_top_left,
                               out_top_right: m_out_top_right,
                               out_bottom_left: m_out_bottom_left,
                               out_bottom_right: m_out_bottom_right,
                               source_col: m_source_col, source_row: m_source_row,
                               tinted: m_tinted, last_block: m_last_block};
                sb.check_block(seen_block);
            end
            if (cfg_valid && cfg_ready) begin
                sb.apply_register(cfg_index_t'(cfg_index), cfg_data);
                cfg_taken++;
            end
            if (s_valid && s_ready) begin
                sb.note_pixel(s_pixel, s_frame_start);
                pixels_taken++;
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin : receiver
        int unsigned mode;
        int unsigned seg;
        int unsigned k;
        int unsigned phase;
        int unsigned stall;
        m_ready = 1'b0;
        phase   = 0;
        stall   = 0;
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(20, 300);
            k    = $urandom_range(2, 5);
            repeat (seg) begin
                @(negedge aclk);
                if (hold_req) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                    hold_req = 1'b0;
                end
                phase++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ((phase % k) != 0);
                    default: begin
                        if (stall > 0) begin
                            m_ready <= 1'b0;
                            stall--;
                        end else begin
                            m_ready <= 1'b1;
                            if ($urandom_range(0, 9) == 0) stall = $urandom_range(1, 8);
                        end
                    end
                endcase
            end
        end
    end

    initial begin
        #(TIMEOUT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_pixel(logic [15:0] px, logic fs);
        int unsigned target;
        target = pixels_taken + 1;
        s_valid       <= 1'b1;
        s_pixel       <= px;
        s_frame_start <= fs;
        do @(negedge aclk); while (pixels_taken < target);
    endtask

    task automatic send_frame(int unsigned n, bit start, int unsigned break_rate);
        int unsigned burst_left;
        int unsigned gap;
        logic fs;
        burst_left = $urandom_range(1, 32);
        for (int unsigned i = 0; i < n; i++) begin
            if (i == 0) fs = start;
            else fs = (break_rate != 0) && ($urandom_range(1, break_rate) == 1);
            send_pixel(random_pixel(), fs);
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                          : $urandom_range(1, 32);
            end
        end
    endtask

    task automatic drain_wait();
        int unsigned waited;
        s_valid <= 1'b0;
        waited = 0;
        do begin
            @(negedge aclk);
            waited++;
        end while (sb.pending_blocks.size() != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_window(logic [6:0] left, logic [6:0] top);
        int unsigned target;
        target = cfg_taken + 2;
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WINDOW_LEFT;
        cfg_data  <= left;
        do @(negedge aclk); while (cfg_taken < target - 1);
        cfg_index <= CFG_WINDOW_TOP;
        cfg_data  <= top;
        do @(negedge aclk); while (cfg_taken < target);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_pixel       = '0;
        s_frame_start = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_WINDOW_LEFT;
        cfg_data      = '0;
        sb = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // row 0 extremes, restart mid-row
        set_window(7'd0, 7'd0);
        foreach (directed_px[i]) send_pixel(directed_px[i], (i == 0) || (i == 13));
        drain_wait();

        // short frames, long hold-off while the sender keeps going
        set_window(7'd0, 7'd0);
        send_frame(200, 1'b1, 0);
        hold_req = 1'b1;
        send_frame(200, 1'b0, 0);
        drain_wait();

        set_window(7'd127, 7'd0);
        send_frame(520, 1'b1, 0);
        drain_wait();

        set_window(7'($urandom_range(0, 127)), 7'd127);
        send_frame(30, 1'b1, 0);
        drain_wait();

        set_window(7'($urandom_range(0, 127)), 7'($urandom_range(0, 1)));
        send_frame(276, 1'b1, 150);
        drain_wait();

        if (sb.pending_blocks.size() != 0)
            sb.report($sformatf("%0d expected blocks never arrived",
                                sb.pending_blocks.size()));
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
